// ===== hw/rtl/ttcsf_pkg.sv =====
// Package: payload types, op codes, states and constants for the tilt color and shock flash block
package ttcsf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W = $clog2(CORDIC_STEPS);
  localparam int CX_W = 36;
  localparam int UV_W = 34;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic signed [UV_W-1:0] UNIT_START = UV_W'(652032874);
  localparam logic signed [UV_W-1:0] Q30_ONE = UV_W'(64'd1 << 30);
  localparam logic signed [MUL_W-1:0] SQRT3_HALF = MUL_W'(929887697);
  localparam logic [15:0] FLASH_FULL = 16'd32768;
  localparam logic [15:0] THRESH_RESET = 16'd1500;
  localparam logic [15:0] DECAY_RESET = 16'd58982;

  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_DECAY = 8'd1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } accel_in_t;

  typedef struct packed {
    logic [15:0] duty_red;
    logic [15:0] duty_green;
    logic [15:0] duty_blue;
    logic [15:0] duty_white;
    logic        shock_seen;
  } duty_out_t;

  typedef enum logic [3:0] {
    OP_XX    = 4'd0,
    OP_YY    = 4'd1,
    OP_ZZ    = 4'd2,
    OP_THR   = 4'd3,
    OP_SQ3   = 4'd4,
    OP_DEC   = 4'd5,
    OP_RED   = 4'd6,
    OP_GREEN = 4'd7,
    OP_BLUE  = 4'd8,
    OP_FLUSH = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CORD = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/tilt_to_color_shock_flash.sv =====
// Top level: tilt angle to RGB duties with a decaying shock flash channel
// Usage:
//   in_valid/in_ready carry one accelerometer word (x, y, z). in_ready is high
//   only while the block is idle; one word is worked on at a time.
//   out_valid/out_ready carry one duty word per input word: red, green, blue,
//   white flash level and a shock flag.
//   cfg_valid/cfg_ready write shock_threshold (index 0) or flash_decay
//   (index 1); other indexes are dropped. cfg_ready is always high.
// Flow: the CORDIC steps run on the shared add/shift unit, then the shared
//   34x34 multiplier forms nine products and one drain, then the output
//   register is loaded. When x and y are both zero the CORDIC steps are
//   skipped. A new word is accepted only after the last one has been loaded
//   into the output register.
// Stall: a finished word holds in the output register until taken; the next
//   word may be accepted and worked on meanwhile, and waits before loading.
// Reset: threshold 1500, decay 58982, flash level zero, both channels empty.
module tilt_to_color_shock_flash
  import ttcsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  accel_in_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output duty_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state_r;
  logic [ITER_W-1:0] iter_r;
  op_t op_r, op_prev_r;
  logic prev_vld_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic signed [UV_W-1:0] u_r, v_r, t2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [31:0] acc_r;
  logic shock_r;
  logic [15:0] flash_r, flash_cur_r, decayed_r;
  logic [15:0] thr_r, decay_r;
  logic [15:0] red_r, green_r, blue_r;
  logic out_valid_r;
  duty_out_t out_r;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [UV_W:0] t1, s_green, s_blue;
  logic signed [CX_W-1:0] cx_in, cy_in;
  logic load_out;

  function automatic logic signed [MUL_W-1:0] duty_base(input logic signed [UV_W:0] s);
    logic signed [UV_W:0] c;
    logic signed [UV_W:0] a;
    c = s;
    if (s > (UV_W+1)'(Q30_ONE)) c = (UV_W+1)'(Q30_ONE);
    if (s < -((UV_W+1)'(Q30_ONE))) c = -((UV_W+1)'(Q30_ONE));
    a = (UV_W+1)'(64'd1 << 29) + (c >>> 1);
    return MUL_W'(a);
  endfunction

  function automatic logic [15:0] duty_of(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = (p + PROD_W'(64'd1 << 44)) >>> 45;
    return r[15:0];
  endfunction

  assign cx_in = CX_W'(in_data.accel_y) <<< 16;
  assign cy_in = CX_W'(in_data.accel_x) <<< 16;
  assign t1 = -((UV_W+1)'(v_r) >>> 1);
  assign s_green = t1 + (UV_W+1)'(t2_r);
  assign s_blue = t1 - (UV_W+1)'(t2_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_XX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      OP_YY: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(y_r);
      end
      OP_ZZ: begin
        mul_a = MUL_W'(z_r);
        mul_b = MUL_W'(z_r);
      end
      OP_THR: begin
        mul_a = MUL_W'({1'b0, thr_r});
        mul_b = MUL_W'({1'b0, thr_r});
      end
      OP_SQ3: begin
        mul_a = SQRT3_HALF;
        mul_b = MUL_W'(u_r);
      end
      OP_DEC: begin
        mul_a = MUL_W'({1'b0, flash_cur_r});
        mul_b = MUL_W'({1'b0, decay_r});
      end
      OP_RED: begin
        mul_a = duty_base((UV_W+1)'(v_r));
        mul_b = duty_base((UV_W+1)'(v_r));
      end
      OP_GREEN: begin
        mul_a = duty_base(s_green);
        mul_b = duty_base(s_green);
      end
      OP_BLUE: begin
        mul_a = duty_base(s_blue);
        mul_b = duty_base(s_blue);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
      decay_r <= DECAY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_THRESHOLD) thr_r <= cfg_data;
      else if (cfg_index == REG_DECAY) decay_r <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r <= '0;
      op_r <= OP_XX;
      op_prev_r <= OP_XX;
      prev_vld_r <= 1'b0;
      flash_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r <= in_data.accel_x;
            y_r <= in_data.accel_y;
            z_r <= in_data.accel_z;
            iter_r <= '0;
            op_r <= OP_XX;
            prev_vld_r <= 1'b0;
            if (in_data.accel_x == '0 && in_data.accel_y == '0) begin
              u_r <= Q30_ONE;
              v_r <= '0;
              state_r <= S_MUL;
            end else begin
              if (cx_in < 0) begin
                cx_r <= -cx_in;
                cy_r <= -cy_in;
                u_r <= -UNIT_START;
              end else begin
                cx_r <= cx_in;
                cy_r <= cy_in;
                u_r <= UNIT_START;
              end
              v_r <= '0;
              state_r <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + (cy_r >>> iter_r);
            cy_r <= cy_r - (cx_r >>> iter_r);
            u_r <= u_r - (v_r >>> iter_r);
            v_r <= v_r + (u_r >>> iter_r);
          end else begin
            cx_r <= cx_r - (cy_r >>> iter_r);
            cy_r <= cy_r + (cx_r >>> iter_r);
            u_r <= u_r + (v_r >>> iter_r);
            v_r <= v_r - (u_r >>> iter_r);
          end
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_W'(CORDIC_STEPS - 1)) state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mul_a * mul_b;
          op_prev_r <= op_r;
          prev_vld_r <= 1'b1;
          if (prev_vld_r) begin
            case (op_prev_r)
              OP_XX: acc_r <= prod_r[31:0];
              OP_YY, OP_ZZ: acc_r <= acc_r + prod_r[31:0];
              OP_THR: begin
                shock_r <= acc_r > prod_r[31:0];
                flash_cur_r <= (acc_r > prod_r[31:0]) ? FLASH_FULL : flash_r;
              end
              OP_SQ3: t2_r <= UV_W'((prod_r + PROD_W'(64'd1 << 29)) >>> 30);
              OP_DEC: decayed_r <= prod_r[31:16];
              OP_RED: red_r <= duty_of(prod_r);
              OP_GREEN: green_r <= duty_of(prod_r);
              OP_BLUE: blue_r <= duty_of(prod_r);
              default: acc_r <= acc_r;
            endcase
          end
          if (op_r == OP_FLUSH) state_r <= S_DONE;
          else op_r <= op_t'(op_r + 4'd1);
        end
        S_DONE: begin
          if (load_out) begin
            out_r.duty_red <= red_r;
            out_r.duty_green <= green_r;
            out_r.duty_blue <= blue_r;
            out_r.duty_white <= flash_cur_r;
            out_r.shock_seen <= shock_r;
            out_valid_r <= 1'b1;
            flash_r <= decayed_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");
  a_flash_full_on_shock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shock_seen |-> out_data.duty_white == FLASH_FULL)
    else $error("shock without full flash");
  a_white_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.duty_white <= FLASH_FULL)
    else $error("flash level out of range");
  a_flash_decays: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> flash_r <= flash_cur_r)
    else $error("flash level grew on decay");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the tilt color and shock flash block: CORDIC duties, flash decay, registers and back-pressure
`timescale 1ns / 100ps
module tb_top;
  import ttcsf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  accel_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  duty_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  duty_out_t duty_queue[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  logic [15:0] thr_q;
  logic [15:0] decay_q;
  logic [15:0] flash_q;

  always #2 clk = ~clk;

  tilt_to_color_shock_flash dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] duty_of_sine(longint s);
    longint a;
    longint unsigned sq;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (s < -64'sd1073741824) s = -64'sd1073741824;
    a = 64'sd536870912 + asr(s, 1);
    sq = longint'(a) * longint'(a);
    return 16'((sq + (64'd1 << 44)) >> 45);
  endfunction

  function automatic duty_out_t predict_duties(accel_in_t w);
    duty_out_t r;
    longint x, y, z, cx, cy, u, v, nx, ny, nu, nv, sn, cs, t1, t2;
    longint unsigned mag2, thr2;
    x = longint'(w.accel_x);
    y = longint'(w.accel_y);
    z = longint'(w.accel_z);
    if (x == 0 && y == 0) begin
      cs = 64'sd1073741824;
      sn = 0;
    end else begin
      cx = y * 65536;
      cy = x * 65536;
      u = 652032874;
      v = 0;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        u = -u;
      end
      for (int i = 0; i < 16; i++) begin
        if (cy >= 0) begin
          nx = cx + asr(cy, i); ny = cy - asr(cx, i);
          nu = u - asr(v, i); nv = v + asr(u, i);
        end else begin
          nx = cx - asr(cy, i); ny = cy + asr(cx, i);
          nu = u + asr(v, i); nv = v - asr(u, i);
        end
        cx = nx; cy = ny; u = nu; v = nv;
      end
      cs = u;
      sn = v;
    end
    t1 = -asr(sn, 1);
    t2 = asr(64'sd929887697 * cs + 64'sd536870912, 30);
    mag2 = x * x + y * y + z * z;
    thr2 = longint'(thr_q) * longint'(thr_q);
    r.shock_seen = mag2 > thr2;
    if (r.shock_seen) flash_q = FLASH_FULL;
    r.duty_red = duty_of_sine(sn);
    r.duty_green = duty_of_sine(t1 + t2);
    r.duty_blue = duty_of_sine(t1 - t2);
    r.duty_white = flash_q;
    flash_q = 16'((32'(flash_q) * 32'(decay_q)) >> 16);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    duty_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (duty_queue.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = duty_queue.pop_front();
        if (out_data.duty_red !== want.duty_red)
          report_mismatch("duty_red", out_data.duty_red, want.duty_red);
        if (out_data.duty_green !== want.duty_green)
          report_mismatch("duty_green", out_data.duty_green, want.duty_green);
        if (out_data.duty_blue !== want.duty_blue)
          report_mismatch("duty_blue", out_data.duty_blue, want.duty_blue);
        if (out_data.duty_white !== want.duty_white)
          report_mismatch("duty_white", out_data.duty_white, want.duty_white);
        if (out_data.shock_seen !== want.shock_seen)
          report_mismatch("shock_seen", out_data.shock_seen, want.shock_seen);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data = '{accel_x: x, accel_y: y, accel_z: z};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    duty_queue.push_back(predict_duties('{accel_x: x, accel_y: y, accel_z: z}));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (duty_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_THRESHOLD) thr_q = val;
    else if (idx == REG_DECAY) decay_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random(int n);
    logic signed [15:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end
        1: begin
          x = 16'($urandom_range(4000)) - 16'sd2000;
          y = 16'($urandom_range(4000)) - 16'sd2000;
          z = 16'($urandom_range(4000)) - 16'sd2000;
        end
        2: begin
          x = 16'($urandom_range(600)) - 16'sd300;
          y = 16'($urandom_range(600)) - 16'sd300;
          z = 16'($urandom_range(600)) - 16'sd300;
        end
        default: begin
          x = ($urandom_range(1)) ? 16'sd0 : 16'($urandom);
          y = ($urandom_range(1)) ? 16'sd0 : 16'($urandom);
          z = 16'($urandom_range(2000));
        end
      endcase
      send_word(x, y, z);
    end
  endtask

  task automatic test_directed;
    send_word(0, 0, 0);
    send_word(0, 0, 1500);
    send_word(0, 0, 1501);
    send_word(0, 0, -1501);
    send_word(1000, 0, 0);
    send_word(-1000, 0, 0);
    send_word(0, 1000, 0);
    send_word(0, -1000, 0);
    send_word(-1000, -1, 0);
    send_word(32767, 32767, 32767);
    send_word(-32768, -32768, -32768);
    send_word(-32768, 32767, 0);
    send_word(32767, -32768, 0);
    send_word(1, 1, 0);
    send_word(-1, 1, 0);
    send_word(707, -707, 0);
    send_word(0, 0, 0);
    send_word(0, 0, 0);
    drain();
  endtask

  task automatic test_registers;
    write_reg(8'd7, 16'h1234);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_DECAY, 16'hFFFF);
    send_word(0, 0, 0);
    send_word(0, 0, 1);
    send_random(40);
    drain();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_DECAY, 16'd0);
    send_random(40);
    drain();
    write_reg(REG_THRESHOLD, 16'd3000);
    write_reg(REG_DECAY, 16'd32768);
    send_random(60);
    drain();
    write_reg(REG_THRESHOLD, THRESH_RESET);
    write_reg(REG_DECAY, DECAY_RESET);
  endtask

  task automatic test_backpressure;
    fork
      hold_cycles = 400;
      send_random(6);
    join
    drain();
  endtask

  task automatic test_random;
    send_idle_pct = 19; recv_idle_pct = 49;
    send_random(350);
    send_idle_pct = 49; recv_idle_pct = 19;
    send_random(350);
    drain();
    write_reg(REG_THRESHOLD, 16'($urandom_range(2500)));
    write_reg(REG_DECAY, 16'($urandom));
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(350);
    drain();
  endtask

  initial begin
    thr_q = THRESH_RESET;
    decay_q = DECAY_RESET;
    flash_q = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

// ===== tilt_to_color_shock_flash.f =====
hw/rtl/ttcsf_pkg.sv
hw/rtl/tilt_to_color_shock_flash.sv
tb/tb_top.sv
